### sv/ctaphid_frame_reassembler_assert.svh
// ----------------------------------------------------------------------------
// ctaphid frame reassembler assertion macros
// concurrent checks on clk with reset masking, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef CTAPHID_FRAME_REASSEMBLER_ASSERT_SVH
`define CTAPHID_FRAME_REASSEMBLER_ASSERT_SVH

`ifndef SYNTH
// property that must hold at every edge outside reset
`define CFR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ctaphid reassembler check failed");
// condition that must never be true outside reset
`define CFR_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ctaphid reassembler forbidden condition");
`else
`define CFR_ASSERT(lbl, clk, rst, prop)
`define CFR_NEVER(lbl, clk, rst, cond)
`endif

`endif

### sv/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// shared constants and types of the ctaphid frame reassembler
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int REPORT_BYTES    = 64;
  localparam int MAX_CONT_FRAMES = 128;
  localparam int INIT_HDR        = 7;
  localparam int CONT_HDR        = 5;
  localparam int MAX_PAYLOAD     = (REPORT_BYTES - INIT_HDR)
                                   + MAX_CONT_FRAMES * (REPORT_BYTES - CONT_HDR);

  localparam int POS_W  = $clog2(REPORT_BYTES);
  localparam int LEN_W  = 13;
  localparam int CID_W  = 32;
  localparam int BYTE_W = 8;

  // byte positions inside a report
  localparam int TYPE_POS   = CONT_HDR - 1;
  localparam int LEN_HI_POS = INIT_HDR - 2;
  localparam int LEN_LO_POS = INIT_HDR - 1;

  localparam int TYPE_BIT = 7;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_INIT      = 2'd1,
    MODE_CONT      = 2'd2,
    MODE_DISCARD   = 2'd3
  } frame_mode_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ABANDON = 2'd2,
    KIND_REJECT  = 2'd3
  } result_kind_t;

endpackage

### sv/ctaphid_frame_reassembler.sv
// ----------------------------------------------------------------------------
// ctaphid_frame_reassembler
// reassembles ctaphid / u2fhid request messages from a stream of report bytes
// ----------------------------------------------------------------------------
// usage
//   input channel: one report byte per transfer (frame_byte), frame_end set on
//   the last byte of each report. bytes 0..3 are the channel id, byte 4 picks
//   init (bit 7 set) or continuation; an init frame carries command and a
//   big-endian length, a continuation frame a sequence number.
//   output channel: at most one result per input byte - a payload byte with
//   its index, a header accepted, a message abandoned or a length rejected.
//   timing: a result is registered and shown in the cycle after its input byte is taken.
//   throughput: one byte per cycle, set by the single register stage that
//   holds the result; the input is taken whenever the result register is
//   empty or is being emptied in the same cycle.
//   stall: while the receiver holds ready low and a result waits, in_ready is
//   low; bytes that cause no result still need the result register free.
//   reset: rst (synchronous) closes any open message, returns to the start of
//   a report and empties the result register.
// ----------------------------------------------------------------------------
`include "ctaphid_frame_reassembler_assert.svh"

module ctaphid_frame_reassembler (
  input  logic                      clk,
  input  logic                      rst,
  // report bytes
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                frame_byte,
  input  logic                      frame_end,
  // results
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                result_kind,
  output logic [31:0]               channel_id,
  output logic [7:0]                command,
  output logic [12:0]               message_length,
  output logic [7:0]                data_byte,
  output logic [12:0]               byte_index,
  output logic                      message_last
);

  localparam int POS_W  = cfr_pkg::POS_W;
  localparam int LEN_W  = cfr_pkg::LEN_W;
  localparam int CID_W  = cfr_pkg::CID_W;
  localparam int BYTE_W = cfr_pkg::BYTE_W;

  // report parsing state
  logic [POS_W-1:0]     frame_position, frame_position_next;
  logic [CID_W-1:0]     frame_cid_shift, frame_cid_shift_next;
  cfr_pkg::frame_mode_t frame_mode, frame_mode_next;
  logic [BYTE_W-1:0]    length_high_byte, length_high_byte_next;

  // open message state
  logic [CID_W-1:0]     message_cid, message_cid_next;
  logic [BYTE_W-1:0]    message_command, message_command_next;
  logic [LEN_W-1:0]     message_total, message_total_next;
  logic [LEN_W-1:0]     bytes_remaining, bytes_remaining_next;
  logic [LEN_W-1:0]     write_index, write_index_next;
  logic [BYTE_W-1:0]    expected_sequence, expected_sequence_next;

  // result produced by the current byte
  logic                  res_valid;
  cfr_pkg::result_kind_t res_kind;
  logic [CID_W-1:0]      res_cid;
  logic [BYTE_W-1:0]     res_cmd;
  logic [LEN_W-1:0]      res_len;
  logic [BYTE_W-1:0]     res_data;
  logic [LEN_W-1:0]      res_index;
  logic                  res_last;

  logic [2*BYTE_W-1:0]   announced_len;
  logic                  short_frame;
  logic                  in_xfer;

  // the result register is free, or is being drained this cycle
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign announced_len = {length_high_byte, frame_byte};

  always_comb begin
    frame_position_next    = frame_position;
    frame_cid_shift_next   = frame_cid_shift;
    frame_mode_next        = frame_mode;
    length_high_byte_next  = length_high_byte;
    message_cid_next       = message_cid;
    message_command_next   = message_command;
    message_total_next     = message_total;
    bytes_remaining_next   = bytes_remaining;
    write_index_next       = write_index;
    expected_sequence_next = expected_sequence;

    res_valid = 1'b0;
    res_kind  = cfr_pkg::KIND_PAYLOAD;
    res_cid   = message_cid;
    res_cmd   = message_command;
    res_len   = message_total;
    res_data  = '0;
    res_index = '0;
    res_last  = 1'b1;

    if (frame_mode != cfr_pkg::MODE_DISCARD) begin
      if (frame_position < POS_W'(cfr_pkg::TYPE_POS)) begin
        // channel id, little-endian
        frame_cid_shift_next = frame_cid_shift
                               | (CID_W'(frame_byte) << {frame_position[1:0], 3'b000});
      end else if (frame_position == POS_W'(cfr_pkg::TYPE_POS)) begin
        if (frame_byte[cfr_pkg::TYPE_BIT]) begin
          // init frame; an open message is dropped
          if (bytes_remaining != '0) begin
            res_valid            = 1'b1;
            res_kind             = cfr_pkg::KIND_ABANDON;
            bytes_remaining_next = '0;
          end
          message_command_next = frame_byte;
          frame_mode_next      = cfr_pkg::MODE_INIT;
        end else if (bytes_remaining != '0 && frame_cid_shift == message_cid &&
                     frame_byte == expected_sequence) begin
          expected_sequence_next = expected_sequence + 1'b1;
          frame_mode_next        = cfr_pkg::MODE_CONT;
        end else begin
          // stray or mismatched continuation
          frame_mode_next = cfr_pkg::MODE_DISCARD;
        end
      end else if (frame_mode == cfr_pkg::MODE_INIT &&
                   frame_position == POS_W'(cfr_pkg::LEN_HI_POS)) begin
        length_high_byte_next = frame_byte;
      end else if (frame_mode == cfr_pkg::MODE_INIT &&
                   frame_position == POS_W'(cfr_pkg::LEN_LO_POS)) begin
        res_valid = 1'b1;
        if (announced_len > (2*BYTE_W)'(cfr_pkg::MAX_PAYLOAD)) begin
          res_kind             = cfr_pkg::KIND_REJECT;
          res_cid              = frame_cid_shift;
          res_cmd              = message_command;
          res_len              = '1;
          bytes_remaining_next = '0;
        end else begin
          message_cid_next       = frame_cid_shift;
          message_total_next     = announced_len[LEN_W-1:0];
          bytes_remaining_next   = announced_len[LEN_W-1:0];
          write_index_next       = '0;
          expected_sequence_next = '0;
          res_kind               = cfr_pkg::KIND_HEADER;
          res_cid                = frame_cid_shift;
          res_cmd                = message_command;
          res_len                = announced_len[LEN_W-1:0];
          res_last               = (announced_len == '0);
        end
      end else if (bytes_remaining != '0) begin
        // payload byte; padding past the length is dropped
        res_valid            = 1'b1;
        res_kind             = cfr_pkg::KIND_PAYLOAD;
        res_data             = frame_byte;
        res_index            = write_index;
        res_last             = (bytes_remaining == LEN_W'(1));
        bytes_remaining_next = bytes_remaining - 1'b1;
        write_index_next     = write_index + 1'b1;
      end
    end

    short_frame = (frame_position < POS_W'(cfr_pkg::TYPE_POS)) ||
                  (frame_position < POS_W'(cfr_pkg::LEN_LO_POS) &&
                   frame_mode_next == cfr_pkg::MODE_INIT);

    if (frame_end) begin
      // report ended; a header left incomplete drops the open message
      if (short_frame && bytes_remaining_next != '0 && !res_valid) begin
        res_valid = 1'b1;
        res_kind  = cfr_pkg::KIND_ABANDON;
        res_cid   = message_cid;
        res_cmd   = message_command;
        res_len   = message_total;
        res_data  = '0;
        res_index = '0;
        res_last  = 1'b1;
      end
      if (short_frame) begin
        bytes_remaining_next = '0;
      end
      frame_position_next   = '0;
      frame_cid_shift_next  = '0;
      frame_mode_next       = cfr_pkg::MODE_UNDECIDED;
      length_high_byte_next = '0;
    end else if (frame_position < POS_W'(cfr_pkg::REPORT_BYTES - 1)) begin
      frame_position_next = frame_position + 1'b1;
    end else begin
      // overlong report, ignore the rest
      frame_mode_next = cfr_pkg::MODE_DISCARD;
    end
  end

  // parsing and message state, updated on every input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position    <= '0;
      frame_cid_shift   <= '0;
      frame_mode        <= cfr_pkg::MODE_UNDECIDED;
      length_high_byte  <= '0;
      message_cid       <= '0;
      message_command   <= '0;
      message_total     <= '0;
      bytes_remaining   <= '0;
      write_index       <= '0;
      expected_sequence <= '0;
    end else if (in_xfer) begin
      frame_position    <= frame_position_next;
      frame_cid_shift   <= frame_cid_shift_next;
      frame_mode        <= frame_mode_next;
      length_high_byte  <= length_high_byte_next;
      message_cid       <= message_cid_next;
      message_command   <= message_command_next;
      message_total     <= message_total_next;
      bytes_remaining   <= bytes_remaining_next;
      write_index       <= write_index_next;
      expected_sequence <= expected_sequence_next;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      result_kind    <= res_kind;
      channel_id     <= res_cid;
      command        <= res_cmd;
      message_length <= res_len;
      data_byte      <= res_data;
      byte_index     <= res_index;
      message_last   <= res_last;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // while a message is open, bytes delivered plus bytes still due make up the announced length
  `CFR_ASSERT(a_count_balance, clk, rst, (bytes_remaining != '0) |-> (LEN_W'(write_index + bytes_remaining) == message_total))
  // a payload result lies inside its message
  `CFR_ASSERT(a_index_in_range, clk, rst, (out_valid && result_kind == cfr_pkg::KIND_PAYLOAD) |-> (byte_index < message_length))
  // discarding only ever starts at or after the type byte
  `CFR_NEVER(a_discard_early, clk, rst, frame_mode == cfr_pkg::MODE_DISCARD && frame_position <= POS_W'(cfr_pkg::TYPE_POS))

endmodule

### tb/sv/ctaphid_frame_reassembler_test.sv
// ----------------------------------------------------------------------------
// ctaphid_frame_reassembler_test
// self-checking bench: feeds report bytes, predicts every result in a model of
// the reassembly state and compares each result transfer field by field
// ----------------------------------------------------------------------------
module ctaphid_frame_reassembler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 2000;
  localparam longint LIMIT_NS = 10_000_000;

  typedef bit [7:0] byte_q_t[$];

  // one result as the block should present it
  typedef struct packed {
    cfr_pkg::result_kind_t kind;
    bit [31:0]             cid;
    bit [7:0]              cmd;
    bit [12:0]             len;
    bit [7:0]              data;
    bit [12:0]             idx;
    bit                    last;
  } reassembly_result_t;

  // --------------------------------------------------------------------------
  // reassembly tracker: mirrors the frame and message state byte by byte and
  // holds the results still owed by the block, oldest first
  // --------------------------------------------------------------------------
  class reassembly_tracker;
    // frame state
    bit [5:0]             pos;
    bit [31:0]            cid_acc;
    cfr_pkg::frame_mode_t mode;
    bit [7:0]             len_hi;
    // message state
    bit [31:0]            msg_cid;
    bit [7:0]             msg_cmd;
    bit [12:0]            msg_total;
    bit [12:0]            remaining;
    bit [12:0]            wr_idx;
    bit [7:0]             seq;
    reassembly_result_t   outputs_due[$];
    int                   errors;
    int                   compared;
    int                   kind_seen[4];

    function new();
      mode = cfr_pkg::MODE_UNDECIDED;
    endfunction

    function int pending();
      return outputs_due.size();
    endfunction

    function reassembly_result_t make_result(cfr_pkg::result_kind_t kind, bit [31:0] cid,
                                             bit [7:0] cmd, bit [12:0] len,
                                             bit [7:0] data, bit [12:0] idx,
                                             bit last);
      reassembly_result_t r;
      r.kind = kind;
      r.cid  = cid;
      r.cmd  = cmd;
      r.len  = len;
      r.data = data;
      r.idx  = idx;
      r.last = last;
      return r;
    endfunction

    // one accepted report byte
    function void absorb_report_byte(bit [7:0] b, bit e);
      reassembly_result_t r;
      bit                 got;
      int                 p;
      bit [15:0]          announced;
      bit                 short_report;
      got = 1'b0;
      p   = int'(pos);
      if (mode != cfr_pkg::MODE_DISCARD) begin
        if (p < cfr_pkg::TYPE_POS) begin
          cid_acc |= 32'(b) << (8 * p);
        end else if (p == cfr_pkg::TYPE_POS) begin
          if (b[cfr_pkg::TYPE_BIT]) begin
            // init frame while a message is open drops that message
            if (remaining != 0) begin
              r = make_result(cfr_pkg::KIND_ABANDON, msg_cid, msg_cmd, msg_total,
                              8'd0, 13'd0, 1'b1);
              got = 1'b1;
              remaining = '0;
            end
            msg_cmd = b;
            mode = cfr_pkg::MODE_INIT;
          end else if (remaining != 0 && cid_acc == msg_cid && b == seq) begin
            seq = seq + 8'd1;
            mode = cfr_pkg::MODE_CONT;
          end else begin
            mode = cfr_pkg::MODE_DISCARD;
          end
        end else if (mode == cfr_pkg::MODE_INIT && p == cfr_pkg::LEN_HI_POS) begin
          len_hi = b;
        end else if (mode == cfr_pkg::MODE_INIT && p == cfr_pkg::LEN_LO_POS) begin
          announced = {len_hi, b};
          if (int'(announced) > cfr_pkg::MAX_PAYLOAD) begin
            r = make_result(cfr_pkg::KIND_REJECT, cid_acc, msg_cmd, '1, 8'd0, 13'd0, 1'b1);
            got = 1'b1;
            remaining = '0;
          end else begin
            msg_cid   = cid_acc;
            msg_total = announced[12:0];
            remaining = announced[12:0];
            wr_idx    = '0;
            seq       = '0;
            r = make_result(cfr_pkg::KIND_HEADER, msg_cid, msg_cmd, msg_total, 8'd0, 13'd0,
                            announced == 0);
            got = 1'b1;
          end
        end else if (remaining != 0) begin
          r = make_result(cfr_pkg::KIND_PAYLOAD, msg_cid, msg_cmd, msg_total, b, wr_idx,
                          remaining == 1);
          got = 1'b1;
          remaining = remaining - 13'd1;
          wr_idx    = wr_idx + 13'd1;
        end
      end

      if (e) begin
        short_report = p < cfr_pkg::TYPE_POS ||
                       (p < cfr_pkg::LEN_LO_POS && mode == cfr_pkg::MODE_INIT);
        if (short_report && remaining != 0 && !got) begin
          r = make_result(cfr_pkg::KIND_ABANDON, msg_cid, msg_cmd, msg_total,
                          8'd0, 13'd0, 1'b1);
          got = 1'b1;
        end
        if (short_report) remaining = '0;
        pos     = '0;
        cid_acc = '0;
        mode    = cfr_pkg::MODE_UNDECIDED;
        len_hi  = '0;
      end else if (p < cfr_pkg::REPORT_BYTES - 1) begin
        pos = 6'(p + 1);
      end else begin
        mode = cfr_pkg::MODE_DISCARD;
      end

      if (got) outputs_due.push_back(r);
    endfunction

    task report(string field, logic [31:0] seen, logic [31:0] want);
      errors++;
      $display("mismatch on %s at result %0d: got %h expected %h",
               field, compared, seen, want);
    endtask

    task compare_output(logic [1:0] kind, logic [31:0] cid, logic [7:0] cmd,
                        logic [12:0] len, logic [7:0] data, logic [12:0] idx,
                        logic last);
      reassembly_result_t w;
      if (outputs_due.size() == 0) begin
        report("unexpected result", {30'd0, kind}, 32'd0);
      end else begin
        w = outputs_due.pop_front();
        if (kind !== w.kind) report("result_kind", 32'(kind), 32'(w.kind));
        if (cid  !== w.cid)  report("channel_id", cid, w.cid);
        if (cmd  !== w.cmd)  report("command", 32'(cmd), 32'(w.cmd));
        if (len  !== w.len)  report("message_length", 32'(len), 32'(w.len));
        if (data !== w.data) report("data_byte", 32'(data), 32'(w.data));
        if (idx  !== w.idx)  report("byte_index", 32'(idx), 32'(w.idx));
        if (last !== w.last) report("message_last", 32'(last), 32'(w.last));
        kind_seen[w.kind]++;
      end
      compared++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  frame_byte = 8'd0;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [31:0] channel_id;
  logic [7:0]  command;
  logic [12:0] message_length;
  logic [7:0]  data_byte;
  logic [12:0] byte_index;
  logic        message_last;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ctaphid_frame_reassembler uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .frame_byte     (frame_byte),
    .frame_end      (frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .channel_id     (channel_id),
    .command        (command),
    .message_length (message_length),
    .data_byte      (data_byte),
    .byte_index     (byte_index),
    .message_last   (message_last)
  );

  reassembly_tracker tracker = new();

  // idling odds: 0 means none, n means a burst starts with chance 1/n
  int        gap_odds = 0;
  int        stall_odds = 0;
  int        stall_left = 0;
  int        items_sent = 0;
  bit [31:0] last_cid = 32'd0;

  // --------------------------------------------------------------------------
  // result side: check every transfer, then decide ready for the next edge
  // (signals read here are the values from before the edge)
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.compare_output(result_kind, channel_id, command, message_length,
                             data_byte, byte_index, message_last);
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      // start a burst with ready held low
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // byte side
  // --------------------------------------------------------------------------

  // one byte transfer; valid stays high across back-to-back bytes
  task automatic send_byte(input bit [7:0] b, input bit e);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    frame_byte <= b;
    frame_end  <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.absorb_report_byte(b, e);
    items_sent++;
  endtask

  task automatic send_report(input byte_q_t rep);
    foreach (rep[i]) send_byte(rep[i], i == rep.size() - 1);
  endtask

  // hold the sender off until every owed result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  function automatic byte_q_t cid_bytes(bit [31:0] cid);
    byte_q_t q;
    q.push_back(cid[7:0]);
    q.push_back(cid[15:8]);
    q.push_back(cid[23:16]);
    q.push_back(cid[31:24]);
    return q;
  endfunction

  function automatic void add_random(ref byte_q_t q, input int n);
    repeat (n) q.push_back(8'($urandom));
  endfunction

  // payload bytes to put in one report: full reports fill to the end, others
  // mostly carry what is left (plus a little padding), sometimes a random share
  function automatic int payload_span(int left, int room, bit full);
    int n;
    if (full) return room;
    case ($urandom_range(0, 3))
      0:       n = $urandom_range(0, room);
      default: n = left + $urandom_range(0, 2);
    endcase
    return (n > room) ? room : n;
  endfunction

  // a frame that should not take part in the open message, or that kills it
  task automatic send_interference(input bit [31:0] cid, input bit [7:0] seq_no);
    byte_q_t rep;
    case ($urandom_range(0, 3))
      0: begin
        // right channel, most likely the wrong sequence
        rep = cid_bytes(cid);
        rep.push_back(8'(seq_no + 8'($urandom_range(1, 255))) & 8'h7f);
        add_random(rep, $urandom_range(0, 15));
      end
      1: begin
        // right sequence, other channel: ignored
        rep = cid_bytes(cid ^ ($urandom | 32'd1));
        rep.push_back(seq_no);
        add_random(rep, $urandom_range(0, 15));
      end
      2: begin
        // report cut inside the channel id: drops the message
        add_random(rep, $urandom_range(1, 4));
      end
      default: begin
        // init header cut before its length: drops the message
        rep = cid_bytes($urandom);
        rep.push_back(8'h80 | 8'($urandom));
        if ($urandom_range(0, 1) == 1) rep.push_back(8'($urandom));
      end
    endcase
    send_report(rep);
  endtask

  // one request message: init frame then continuation frames in order
  task automatic send_message(input bit [31:0] cid, input bit [7:0] cmd, input int len,
                              input bit full, input bit cut, input bit noisy);
    byte_q_t  rep;
    int       left;
    int       n;
    bit [7:0] seq_no;
    left   = len;
    seq_no = 8'd0;
    last_cid = cid;
    rep = cid_bytes(cid);
    rep.push_back(cmd);
    rep.push_back(8'(len >> 8));
    rep.push_back(8'(len));
    n = payload_span(left, cfr_pkg::REPORT_BYTES - cfr_pkg::INIT_HDR, full);
    add_random(rep, n);
    left -= (n > left) ? left : n;
    send_report(rep);
    while (left > 0) begin
      // leave the message open for whatever comes next
      if (cut && $urandom_range(0, 3) == 0) return;
      if (noisy && $urandom_range(0, 9) == 0) send_interference(cid, seq_no);
      rep = cid_bytes(cid);
      rep.push_back(seq_no);
      n = payload_span(left, cfr_pkg::REPORT_BYTES - cfr_pkg::CONT_HDR, full);
      add_random(rep, n);
      // overlong report: bytes past the report size are dropped
      if (rep.size() == cfr_pkg::REPORT_BYTES && noisy && $urandom_range(0, 7) == 0)
        add_random(rep, $urandom_range(1, 8));
      left -= (n > left) ? left : n;
      send_report(rep);
      seq_no++;
    end
  endtask

  // 256 header-only continuations so the sequence number wraps to zero
  task automatic send_sequence_wrap();
    byte_q_t   rep;
    bit [31:0] cid;
    cid = $urandom;
    rep = cid_bytes(cid);
    rep.push_back(8'h80 | 8'($urandom));
    rep.push_back(8'd0);
    rep.push_back(8'd4);
    add_random(rep, 1);
    send_report(rep);
    for (int s = 0; s < 256; s++) begin
      rep = cid_bytes(cid);
      rep.push_back(8'(s));
      send_report(rep);
    end
    rep = cid_bytes(cid);
    rep.push_back(8'd0);
    add_random(rep, 3);
    send_report(rep);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    byte_q_t   rep;
    int        len;
    int        pick;
    bit        did_wrap;
    bit        did_max;
    bit [31:0] cid;
    bit [7:0]  cmd;
    did_wrap = 1'b0;
    did_max  = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: lowest channel and command with two payload extremes
    rep = cid_bytes(32'h0000_0000);
    rep.push_back(8'h80);
    rep.push_back(8'h00);
    rep.push_back(8'h02);
    rep.push_back(8'h00);
    rep.push_back(8'hff);
    send_report(rep);
    // highest channel, command and length: rejected, length saturated
    rep = cid_bytes(32'hffff_ffff);
    rep.push_back(8'hff);
    rep.push_back(8'hff);
    rep.push_back(8'hff);
    send_report(rep);
    // empty message: header alone completes it
    rep = cid_bytes(32'h5aa5_c33c);
    rep.push_back(8'h81);
    rep.push_back(8'h00);
    rep.push_back(8'h00);
    send_report(rep);
    drain_results();

    // random part: mostly well-formed messages, the rest noise and breakage
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > RANDOM_ITEMS * 4 / 5) begin
        // closing stretch runs flat out
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: gap_odds = 0;
          1: gap_odds = 3;
          2: gap_odds = 8;
          default: gap_odds = 20;
        endcase
        case ($urandom_range(0, 3))
          0: stall_odds = 0;
          1: stall_odds = 3;
          2: stall_odds = 8;
          default: stall_odds = 20;
        endcase
      end

      if (!did_wrap && items_sent > RANDOM_ITEMS / 5) begin
        send_sequence_wrap();
        did_wrap = 1'b1;
      end
      if (!did_max && items_sent > RANDOM_ITEMS / 2) begin
        // largest length accepted; a later init frame or short report abandons it
        rep = cid_bytes($urandom);
        rep.push_back(8'h80 | 8'($urandom));
        rep.push_back(8'(cfr_pkg::MAX_PAYLOAD >> 8));
        rep.push_back(8'(cfr_pkg::MAX_PAYLOAD));
        add_random(rep, cfr_pkg::REPORT_BYTES - cfr_pkg::INIT_HDR);
        send_report(rep);
        did_max = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(0, 3);
          1, 2:    len = $urandom_range(81, 300);
          default: len = $urandom_range(1, 80);
        endcase
        cmd = ($urandom_range(0, 7) == 0) ? 8'hff : (8'h80 | 8'($urandom));
        send_message($urandom, cmd, len, $urandom_range(0, 3) == 0,
                     $urandom_range(0, 5) == 0, 1'b1);
      end else if (pick < 70) begin
        // length over the limit, possibly with trailing bytes
        case ($urandom_range(0, 2))
          0:       len = cfr_pkg::MAX_PAYLOAD + 1;
          1:       len = 16'hffff;
          default: len = $urandom_range(cfr_pkg::MAX_PAYLOAD + 1, 16'hffff);
        endcase
        rep = cid_bytes($urandom);
        rep.push_back(8'h80 | 8'($urandom));
        rep.push_back(8'(len >> 8));
        rep.push_back(8'(len));
        add_random(rep, $urandom_range(0, 10));
        send_report(rep);
      end else if (pick < 78) begin
        // short report of any kind
        rep.delete();
        add_random(rep, $urandom_range(1, 6));
        send_report(rep);
      end else if (pick < 88) begin
        // raw noise, overlong reports included
        rep.delete();
        add_random(rep, $urandom_range(1, 80));
        send_report(rep);
      end else if (pick < 96) begin
        // stray continuation
        cid = ($urandom_range(0, 1) == 1) ? last_cid : 32'($urandom);
        rep = cid_bytes(cid);
        rep.push_back(8'($urandom) & 8'h7f);
        add_random(rep, $urandom_range(0, 20));
        send_report(rep);
      end else if (items_sent <= RANDOM_ITEMS * 4 / 5) begin
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("%0d report bytes sent; results checked: %0d payload, %0d headers,",
             items_sent, tracker.kind_seen[cfr_pkg::KIND_PAYLOAD],
             tracker.kind_seen[cfr_pkg::KIND_HEADER]);
    $display("%0d abandoned, %0d rejected, %0d mismatches",
             tracker.kind_seen[cfr_pkg::KIND_ABANDON],
             tracker.kind_seen[cfr_pkg::KIND_REJECT], tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ctaphid_frame_reassembler] OK");
    end else begin
      $display("[ctaphid_frame_reassembler] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results still owed", tracker.pending());
    $display("[ctaphid_frame_reassembler] ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/cfr_pkg.sv
sv/ctaphid_frame_reassembler.sv
tb/sv/ctaphid_frame_reassembler_test.sv
